FILE: sv/twar_pkg.sv
// shared constants and types for the trace window auto-range block
`timescale 1ns / 1ps

package twar_pkg;

	// data path width of samples, stored values and limits
	localparam int DATA_W = 32;

	// number of sample and stored ports on the block
	localparam int NUM_PORTS = 5;

	// configuration register index width and indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BEAMS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PASS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_RANGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_MAX  = 3'd4;

	typedef logic signed [DATA_W-1:0] sample_t;

endpackage

FILE: sv/twar_ram.sv
// generic simple dual port ram with one write port and a registered read port
`timescale 1ns / 1ps

module twar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1280
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/trace_window_autorange_unit.sv
// sliding trace window with low-pass option and auto-ranging min/max rescan or fixed limits
// sequence: per active channel read the dropped value, read the previous slot, write the
//   new value; then a limit check, an optional rescan and the result register
// throughput: one request at a time; the full rescan reads one stored value per cycle
//   from the history ram
// reset: history ram is swept to zero after reset, during which no request is taken;
//   configuration writes are taken during the sweep and between requests, ahead of a
//   waiting request
`timescale 1ns / 1ps

module trace_window_autorange_unit #(
	parameter int WINDOW   = 256,
	parameter int CHANNELS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [twar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twar_pkg::DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [twar_pkg::DATA_W-1:0] sample_a,
	input  logic signed [twar_pkg::DATA_W-1:0] sample_b,
	input  logic signed [twar_pkg::DATA_W-1:0] sample_c,
	input  logic signed [twar_pkg::DATA_W-1:0] sample_d,
	input  logic signed [twar_pkg::DATA_W-1:0] sample_e,
	// output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [twar_pkg::DATA_W-1:0] stored_a,
	output logic signed [twar_pkg::DATA_W-1:0] stored_b,
	output logic signed [twar_pkg::DATA_W-1:0] stored_c,
	output logic signed [twar_pkg::DATA_W-1:0] stored_d,
	output logic signed [twar_pkg::DATA_W-1:0] stored_e,
	output logic signed [twar_pkg::DATA_W-1:0] range_low,
	output logic signed [twar_pkg::DATA_W-1:0] range_high
);

	localparam int DW        = twar_pkg::DATA_W;
	localparam int IW        = $clog2(WINDOW);
	localparam int BW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NBW       = $clog2(CHANNELS + 1);
	localparam int RAM_DEPTH = CHANNELS << IW;
	localparam int AW        = $clog2(RAM_DEPTH);

	// sequencer states
	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_RD_OLD  = 3'd2;
	localparam logic [2:0] ST_RD_PREV = 3'd3;
	localparam logic [2:0] ST_WRITE   = 3'd4;
	localparam logic [2:0] ST_CHECK   = 3'd5;
	localparam logic [2:0] ST_SCAN    = 3'd6;
	localparam logic [2:0] ST_OUT     = 3'd7;

	logic [2:0]           st_q;
	logic [AW-1:0]        clr_q;
	logic [IW-1:0]        ptr_q;
	logic [IW-1:0]        prev_ptr;
	logic [IW-1:0]        si_q;
	logic [NBW-1:0]       ch_q;
	logic [NBW-1:0]       nb;
	logic                 last_ch;
	logic                 issue_q;
	logic                 vld_s1;
	logic                 recalc_q;
	logic                 need_q;
	logic                 out_valid_q;
	logic                 out_load;

	// configuration registers
	logic [2:0]           num_beams_q;
	logic                 low_pass_q;
	logic                 auto_range_q;
	twar_pkg::sample_t    fixed_min_q;
	twar_pkg::sample_t    fixed_max_q;

	// tracked limits
	twar_pkg::sample_t    tl_q;
	twar_pkg::sample_t    th_q;

	// request payload and per-request stored values
	twar_pkg::sample_t    samp_q   [CHANNELS];
	twar_pkg::sample_t    stored_q [twar_pkg::NUM_PORTS];
	twar_pkg::sample_t    out_st_q [twar_pkg::NUM_PORTS];
	twar_pkg::sample_t    out_lo_q;
	twar_pkg::sample_t    out_hi_q;

	// ram ports
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [DW-1:0]        ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [DW-1:0]        ram_rdata;
	logic [AW-1:0]        addr_cur;
	logic [AW-1:0]        addr_prev;
	logic [AW-1:0]        addr_scan;

	twar_pkg::sample_t    rd_val;
	twar_pkg::sample_t    cur_samp;
	logic signed [DW:0]   avg_sum;
	logic signed [DW:0]   avg_adj;
	twar_pkg::sample_t    new_val;
	logic                 old_hit;
	logic                 new_hit;

	twar_ram #(
		.WIDTH (DW),
		.DEPTH (RAM_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// active channel count, clamped
	assign nb       = (num_beams_q > 3'(CHANNELS)) ? NBW'(CHANNELS) : NBW'(num_beams_q);
	assign last_ch  = (ch_q == nb - NBW'(1));
	assign prev_ptr = (ptr_q == '0) ? IW'(WINDOW - 1) : ptr_q - IW'(1);

	// history addresses: channel in the upper bits, slot in the lower bits
	assign addr_cur  = AW'({ch_q[BW-1:0], ptr_q});
	assign addr_prev = AW'({ch_q[BW-1:0], prev_ptr});
	assign addr_scan = AW'({ch_q[BW-1:0], si_q});

	assign rd_val = ram_rdata;

	// sample of the current channel
	always_comb begin
		cur_samp = '0;
		for (int b = 0; b < CHANNELS; b++) begin
			if (ch_q == NBW'(b)) begin
				cur_samp = samp_q[b];
			end
		end
	end

	// low-pass average truncated toward zero
	assign avg_sum = {rd_val[DW-1], rd_val} + {cur_samp[DW-1], cur_samp};
	assign avg_adj = avg_sum + {{DW{1'b0}}, avg_sum[DW]};
	assign new_val = low_pass_q ? avg_adj[DW:1] : cur_samp;

	// limit hits for the dropped and the incoming value
	assign old_hit = (rd_val <= tl_q) || (rd_val >= th_q);
	assign new_hit = (new_val <= tl_q) || (new_val >= th_q);

	// ram access selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_cur;
		ram_wdata = new_val;
		if (st_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (st_q == ST_WRITE) begin
			ram_we = 1'b1;
		end
		unique case (st_q)
			ST_RD_OLD:  ram_raddr = addr_cur;
			ST_RD_PREV: ram_raddr = addr_prev;
			default:    ram_raddr = addr_scan;
		endcase
	end

	// configuration only while no request is in flight, and ahead of a new one
	assign out_load  = (st_q == ST_OUT) && (!out_valid_q || out_ready);
	assign in_ready  = (st_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (st_q == ST_IDLE) || (st_q == ST_CLEAR);

	// sequencer, tracked limits and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			clr_q        <= '0;
			ptr_q        <= '0;
			si_q         <= '0;
			ch_q         <= '0;
			issue_q      <= 1'b0;
			vld_s1       <= 1'b0;
			recalc_q     <= 1'b0;
			need_q       <= 1'b1;
			out_valid_q  <= 1'b0;
			tl_q         <= '0;
			th_q         <= '0;
			num_beams_q  <= '0;
			low_pass_q   <= 1'b0;
			auto_range_q <= 1'b1;
			fixed_min_q  <= '0;
			fixed_max_q  <= '0;
		end else begin
			vld_s1 <= issue_q;
			// result register handshake
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(RAM_DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						recalc_q <= 1'b0;
						ch_q     <= '0;
						st_q     <= (nb == '0) ? ST_CHECK : ST_RD_OLD;
					end
				end
				ST_RD_OLD: begin
					st_q <= ST_RD_PREV;
				end
				ST_RD_PREV: begin
					if (old_hit) begin
						recalc_q <= 1'b1;
					end
					st_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (new_hit) begin
						recalc_q <= 1'b1;
					end
					if (last_ch) begin
						st_q <= ST_CHECK;
					end else begin
						ch_q <= ch_q + NBW'(1);
						st_q <= ST_RD_OLD;
					end
				end
				ST_CHECK: begin
					ptr_q <= (ptr_q == IW'(WINDOW - 1)) ? '0 : ptr_q + IW'(1);
					if (auto_range_q && (recalc_q || need_q)) begin
						need_q  <= 1'b0;
						tl_q    <= '0;
						th_q    <= '0;
						ch_q    <= '0;
						si_q    <= '0;
						issue_q <= (nb != '0);
						st_q    <= ST_SCAN;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					// issue one read per cycle over every active slot
					if (issue_q) begin
						if (si_q == IW'(WINDOW - 1)) begin
							si_q <= '0;
							if (last_ch) begin
								issue_q <= 1'b0;
							end else begin
								ch_q <= ch_q + NBW'(1);
							end
						end else begin
							si_q <= si_q + IW'(1);
						end
					end
					// fold returned value into the limits
					if (vld_s1) begin
						if (rd_val < tl_q) begin
							tl_q <= rd_val;
						end
						if (rd_val > th_q) begin
							th_q <= rd_val;
						end
					end
					if (!issue_q && !vld_s1) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					twar_pkg::REG_NUM_BEAMS:  num_beams_q <= cfg_data[2:0];
					twar_pkg::REG_LOW_PASS:   low_pass_q  <= cfg_data[0];
					twar_pkg::REG_AUTO_RANGE: begin
						if (cfg_data[0] && !auto_range_q) begin
							need_q <= 1'b1;
						end
						auto_range_q <= cfg_data[0];
					end
					twar_pkg::REG_FIXED_MIN:  fixed_min_q <= cfg_data;
					twar_pkg::REG_FIXED_MAX:  fixed_max_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// request payload, stored values and result register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int b = 0; b < CHANNELS; b++) begin
				unique case (b)
					0:       samp_q[b] <= sample_a;
					1:       samp_q[b] <= sample_b;
					2:       samp_q[b] <= sample_c;
					3:       samp_q[b] <= sample_d;
					default: samp_q[b] <= sample_e;
				endcase
			end
			for (int b = 0; b < twar_pkg::NUM_PORTS; b++) begin
				stored_q[b] <= '0;
			end
		end
		if (st_q == ST_WRITE) begin
			for (int b = 0; b < CHANNELS; b++) begin
				if (ch_q == NBW'(b)) begin
					stored_q[b] <= new_val;
				end
			end
		end
		if (out_load) begin
			for (int b = 0; b < twar_pkg::NUM_PORTS; b++) begin
				out_st_q[b] <= stored_q[b];
			end
			out_lo_q <= auto_range_q ? tl_q : fixed_min_q;
			out_hi_q <= auto_range_q ? th_q : fixed_max_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign stored_a   = out_st_q[0];
	assign stored_b   = out_st_q[1];
	assign stored_c   = out_st_q[2];
	assign stored_d   = out_st_q[3];
	assign stored_e   = out_st_q[4];
	assign range_low  = out_lo_q;
	assign range_high = out_hi_q;

endmodule
